[hw/rtl/multi_policy_job_scheduler_defines.svh]
// Assertion macros for the job scheduler.
`ifndef MULTI_POLICY_JOB_SCHEDULER_DEFINES_SVH
`define MULTI_POLICY_JOB_SCHEDULER_DEFINES_SVH

// Check a plain invariant on every clock edge out of reset.
`define MPJS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check an implication on every clock edge out of reset.
`define MPJS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mpjs_pkg.sv]
// Shared types, codes and helpers for the job scheduler.
package mpjs_pkg;

  localparam int unsigned MAX_JOBS = 32;
  localparam int unsigned IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

  typedef enum logic [1:0] {
    OP_NEW    = 2'd0,
    OP_EXPIRE = 2'd1,
    OP_FINISH = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  localparam logic [2:0] POL_FCFS     = 3'd0;
  localparam logic [2:0] POL_PRIO     = 3'd1;
  localparam logic [2:0] POL_PRIO_PRE = 3'd2;
  localparam logic [2:0] POL_SRTF     = 3'd3;
  localparam logic [2:0] POL_RR       = 3'd4;
  localparam logic [2:0] POL_SJF      = 3'd5;

  typedef struct packed {
    logic [15:0] number;
    logic [15:0] rank;
    logic [31:0] arrival;
    logic [31:0] length;
    logic [31:0] executed;
    logic [31:0] last_start;
    logic [31:0] first_run;
    logic [31:0] rr_stamp;
  } entry_t;

  // Primary ordering key of an entry under a policy.
  function automatic logic [31:0] key_of(logic [2:0] policy, entry_t rec);
    logic [31:0] key;
    unique case (policy)
      POL_PRIO, POL_PRIO_PRE: key = {16'd0, rec.rank};
      POL_SRTF: key = (rec.executed > rec.length) ? 32'd0 : rec.length - rec.executed;
      POL_RR:   key = rec.rr_stamp;
      POL_SJF:  key = rec.length;
      default:  key = rec.arrival;
    endcase
    return key;
  endfunction

endpackage

[hw/rtl/mpjs_table_ram.sv]
// Job table memory: one write port, one registered read port.
module mpjs_table_ram import mpjs_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [MAX_JOBS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/mpjs_picker.sv]
// Running best-candidate search over a stream of table entries.
module mpjs_picker import mpjs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             cand_valid_i,
  input  logic [IDX_W-1:0] cand_idx_i,
  input  entry_t           cand_rec_i,
  input  logic [2:0]       policy_i,
  output logic             best_found_o,
  output logic [IDX_W-1:0] best_idx_o,
  output entry_t           best_rec_o
);

  logic             s1_vld_q;
  logic [IDX_W-1:0] s1_idx_q;
  entry_t           s1_rec_q;
  logic [31:0]      s1_key_q;

  logic             best_found_q;
  logic [IDX_W-1:0] best_idx_q;
  entry_t           best_rec_q;
  logic [31:0]      best_key_q;

  logic wins;
  logic take;

  // Candidates come in rising index order, so a full tie keeps the holder.
  always_comb begin
    wins = (s1_key_q < best_key_q) ||
           ((s1_key_q == best_key_q) &&
            ((s1_rec_q.arrival < best_rec_q.arrival) ||
             ((s1_rec_q.arrival == best_rec_q.arrival) &&
              (s1_rec_q.number < best_rec_q.number))));
    take = s1_vld_q && (!best_found_q || wins);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q     <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      s1_vld_q <= cand_valid_i && !clear_i;
      if (clear_i) begin
        best_found_q <= 1'b0;
      end else if (take) begin
        best_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= cand_idx_i;
    s1_rec_q <= cand_rec_i;
    s1_key_q <= key_of(policy_i, cand_rec_i);
    if (take) begin
      best_idx_q <= s1_idx_q;
      best_rec_q <= s1_rec_q;
      best_key_q <= s1_key_q;
    end
  end

  assign best_found_o = best_found_q;
  assign best_idx_o   = best_idx_q;
  assign best_rec_o   = best_rec_q;

endmodule

[hw/rtl/multi_policy_job_scheduler.sv]
// Job table scheduler with six selectable policies and saturating finish totals.
// One item at a time is processed. A new job is written to the lowest free entry
// unless the table is full; a finish does one lookup pass over the table memory,
// one entry read per cycle, and updates the totals only when the job is found; a quantum
// expiry does a lookup pass for the running job, then a selection pass for the
// best candidate unless a non-preemptive policy keeps a found running job.
// The result sits in an output register, so the next item is taken while it waits.
module multi_policy_job_scheduler import mpjs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] job_id_i,
  input  logic        evicted_valid_i,
  input  logic [31:0] now_i,
  input  logic [31:0] run_length_i,
  input  logic [15:0] job_priority_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic        next_valid_o,
  output logic [15:0] next_job_o,
  output logic [47:0] total_wait_o,
  output logic [47:0] total_turnaround_o,
  output logic [47:0] resp_total_o,
  output logic [31:0] finished_count_o
);

`include "multi_policy_job_scheduler_defines.svh"

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NEW    = 4'd1;
  localparam logic [3:0] S_SCAN1  = 4'd2;
  localparam logic [3:0] S_DRAIN1 = 4'd3;
  localparam logic [3:0] S_CHG1   = 4'd4;
  localparam logic [3:0] S_CHG2   = 4'd5;
  localparam logic [3:0] S_SCAN2  = 4'd6;
  localparam logic [3:0] S_DRAIN2 = 4'd7;
  localparam logic [3:0] S_START  = 4'd8;
  localparam logic [3:0] S_FIN1   = 4'd9;
  localparam logic [3:0] S_FIN2   = 4'd10;
  localparam logic [3:0] S_FIN3   = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_JOBS - 1);

  logic [3:0]          state_q;
  logic [2:0]          policy_q;
  logic [MAX_JOBS-1:0] used_q, queued_q, started_q;
  logic [IDX_W-1:0]    cnt_q;
  logic [1:0]          drain_q;
  logic                rd_vld_q, rd_p2_q;
  logic [IDX_W-1:0]    rd_idx_q;

  op_e         op_q;
  logic [15:0] id_q, pri_q;
  logic        ev_q;
  logic [31:0] now_q, len_q;

  logic             found_q, sel_run_q;
  logic [IDX_W-1:0] hit_idx_q;
  entry_t           hit_rec_q;
  logic [31:0]      delta_q, turn_q, resp_q, wait_q;

  logic        res_status_q, res_nvalid_q;
  logic [15:0] res_njob_q;
  logic [47:0] wait_sum_q, turn_sum_q, resp_sum_q;
  logic [31:0] done_q;

  logic        out_valid_q, out_status_q, out_nvalid_q;
  logic [15:0] out_njob_q;
  logic [47:0] out_wait_q, out_turn_q, out_resp_q;
  logic [31:0] out_done_q;

  entry_t           rd_rec;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] free_idx;
  logic             full;
  logic             run_cand, pre_pol;
  logic             match1, cand_valid;
  logic             best_found;
  logic [IDX_W-1:0] best_idx;
  entry_t           best_rec;
  logic             ch_found;
  logic [IDX_W-1:0] ch_idx;
  entry_t           ch_rec, charged_rec, new_rec, start_rec;
  logic [32:0]      exec_sum;
  logic             out_load;

  function automatic logic [47:0] sat48(logic [47:0] acc, logic [31:0] v);
    logic [48:0] s;
    s = {1'b0, acc} + {17'd0, v};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  mpjs_table_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (cnt_q),
    .rdata_o (rd_rec)
  );

  mpjs_picker u_picker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      ((state_q == S_SCAN2) && (cnt_q == '0)),
    .cand_valid_i (cand_valid),
    .cand_idx_i   (rd_idx_q),
    .cand_rec_i   (rd_rec),
    .policy_i     (policy_q),
    .best_found_o (best_found),
    .best_idx_o   (best_idx),
    .best_rec_o   (best_rec)
  );

  // Lowest free entry.
  always_comb begin
    free_idx = '0;
    for (int i = MAX_JOBS - 1; i >= 0; i--) begin
      if (!used_q[i]) free_idx = IDX_W'(i);
    end
    full = &used_q;
  end

  always_comb begin
    pre_pol  = (policy_q == POL_PRIO_PRE) || (policy_q == POL_SRTF) ||
               (policy_q == POL_RR);
    run_cand = found_q && (op_q == OP_EXPIRE) && pre_pol;
    match1   = rd_vld_q && !rd_p2_q && used_q[rd_idx_q] && (rd_rec.number == id_q) &&
               ((op_q == OP_FINISH) || (ev_q && !queued_q[rd_idx_q]));
    cand_valid = rd_vld_q && rd_p2_q && used_q[rd_idx_q] &&
                 (queued_q[rd_idx_q] || (run_cand && (rd_idx_q == hit_idx_q)));

    exec_sum    = {1'b0, hit_rec_q.executed} + {1'b0, delta_q};
    charged_rec = hit_rec_q;
    charged_rec.executed   = exec_sum[32] ? 32'hFFFF_FFFF : exec_sum[31:0];
    charged_rec.last_start = now_q;
    if (policy_q == POL_RR) charged_rec.rr_stamp = now_q;

    new_rec            = '0;
    new_rec.number     = id_q;
    new_rec.rank       = pri_q;
    new_rec.arrival    = now_q;
    new_rec.length     = len_q;
    new_rec.last_start = now_q;
    new_rec.rr_stamp   = now_q;

    ch_found = sel_run_q || best_found;
    ch_idx   = sel_run_q ? hit_idx_q : best_idx;
    ch_rec   = sel_run_q ? hit_rec_q : best_rec;
    start_rec = ch_rec;
    start_rec.last_start = now_q;
    if (!started_q[ch_idx]) start_rec.first_run = now_q;

    mem_re    = (state_q == S_SCAN1) || (state_q == S_SCAN2);
    mem_we    = 1'b0;
    mem_waddr = free_idx;
    mem_wdata = new_rec;
    unique case (state_q)
      S_NEW: begin
        mem_we = !full;
      end
      S_CHG2: begin
        mem_we    = 1'b1;
        mem_waddr = hit_idx_q;
        mem_wdata = charged_rec;
      end
      S_START: begin
        mem_we    = ch_found;
        mem_waddr = ch_idx;
        mem_wdata = start_rec;
      end
      default: ;
    endcase

    out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      policy_q    <= POL_FCFS;
      used_q      <= '0;
      queued_q    <= '0;
      started_q   <= '0;
      cnt_q       <= '0;
      drain_q     <= '0;
      rd_vld_q    <= 1'b0;
      rd_p2_q     <= 1'b0;
      found_q     <= 1'b0;
      sel_run_q   <= 1'b0;
      wait_sum_q  <= '0;
      turn_sum_q  <= '0;
      resp_sum_q  <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) policy_q <= cfg_wdata_i;
      rd_vld_q <= mem_re;
      rd_p2_q  <= (state_q == S_SCAN2);
      if (match1 && !found_q) found_q <= 1'b1;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            found_q   <= 1'b0;
            sel_run_q <= 1'b0;
            cnt_q     <= '0;
            unique case (op_e'(operation_i))
              OP_NEW:               state_q <= S_NEW;
              OP_EXPIRE, OP_FINISH: state_q <= S_SCAN1;
              default:              state_q <= S_OUT;
            endcase
          end
        end
        S_NEW: begin
          if (!full) begin
            used_q[free_idx]    <= 1'b1;
            queued_q[free_idx]  <= 1'b1;
            started_q[free_idx] <= 1'b0;
          end
          state_q <= S_OUT;
        end
        S_SCAN1, S_SCAN2: begin
          if (cnt_q == LAST_IDX) begin
            drain_q <= '0;
            state_q <= (state_q == S_SCAN1) ? S_DRAIN1 : S_DRAIN2;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DRAIN1: begin
          drain_q <= drain_q + 1'b1;
          if (drain_q == 2'd2) begin
            cnt_q <= '0;
            if (op_q == OP_FINISH) begin
              state_q <= found_q ? S_FIN1 : S_OUT;
            end else begin
              state_q <= found_q ? S_CHG1 : S_SCAN2;
            end
          end
        end
        S_CHG1: begin
          state_q <= S_CHG2;
        end
        S_CHG2: begin
          cnt_q     <= '0;
          sel_run_q <= !pre_pol;
          state_q   <= pre_pol ? S_SCAN2 : S_START;
        end
        S_DRAIN2: begin
          drain_q <= drain_q + 1'b1;
          if (drain_q == 2'd2) state_q <= S_START;
        end
        S_START: begin
          if (ch_found) begin
            // Requeue a preempted job, then hand the slot to the chosen one.
            if (found_q && (ch_idx != hit_idx_q)) queued_q[hit_idx_q] <= 1'b1;
            queued_q[ch_idx]  <= 1'b0;
            started_q[ch_idx] <= 1'b1;
          end
          state_q <= S_OUT;
        end
        S_FIN1: begin
          used_q[hit_idx_q]    <= 1'b0;
          queued_q[hit_idx_q]  <= 1'b0;
          started_q[hit_idx_q] <= 1'b0;
          state_q <= S_FIN2;
        end
        S_FIN2: begin
          state_q <= S_FIN3;
        end
        S_FIN3: begin
          wait_sum_q <= sat48(wait_sum_q, wait_q);
          turn_sum_q <= sat48(turn_sum_q, turn_q);
          resp_sum_q <= sat48(resp_sum_q, resp_q);
          if (done_q != 32'hFFFF_FFFF) done_q <= done_q + 32'd1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    if ((state_q == S_IDLE) && in_valid_i) begin
      op_q         <= op_e'(operation_i);
      id_q         <= job_id_i;
      ev_q         <= evicted_valid_i;
      now_q        <= now_i;
      len_q        <= run_length_i;
      pri_q        <= job_priority_i;
      res_status_q <= 1'b0;
      res_nvalid_q <= 1'b0;
      res_njob_q   <= '0;
    end
    if (match1 && !found_q) begin
      hit_idx_q <= rd_idx_q;
      hit_rec_q <= rd_rec;
    end
    if (state_q == S_NEW) res_status_q <= full;
    if (state_q == S_CHG1) delta_q <= now_q - hit_rec_q.last_start;
    if (state_q == S_CHG2) hit_rec_q <= charged_rec;
    if ((state_q == S_START) && ch_found) begin
      res_nvalid_q <= 1'b1;
      res_njob_q   <= ch_rec.number;
    end
    if (state_q == S_FIN1) begin
      turn_q <= now_q - hit_rec_q.arrival;
      resp_q <= started_q[hit_idx_q] ? hit_rec_q.first_run - hit_rec_q.arrival : 32'd0;
    end
    if (state_q == S_FIN2) begin
      wait_q <= (turn_q > hit_rec_q.length) ? turn_q - hit_rec_q.length : 32'd0;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_nvalid_q <= res_nvalid_q;
      out_njob_q   <= res_njob_q;
      out_wait_q   <= wait_sum_q;
      out_turn_q   <= turn_sum_q;
      out_resp_q   <= resp_sum_q;
      out_done_q   <= done_q;
    end
  end

  assign in_stall_o         = (state_q != S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign next_valid_o       = out_nvalid_q;
  assign next_job_o         = out_njob_q;
  assign total_wait_o       = out_wait_q;
  assign total_turnaround_o = out_turn_q;
  assign resp_total_o       = out_resp_q;
  assign finished_count_o   = out_done_q;

  `MPJS_ASSERT_ALWAYS(a_queued_used, (queued_q & ~used_q) == '0, "queued entry not in use")
  `MPJS_ASSERT_ALWAYS(a_started_used, (started_q & ~used_q) == '0, "started entry not in use")
  `MPJS_ASSERT_IMPLY(a_idle_job, out_valid_o && !next_valid_o, next_job_o == 16'd0, "stray job")
  `MPJS_ASSERT_IMPLY(a_done_step, done_q != $past(done_q), done_q == $past(done_q) + 32'd1, "count jump")

endmodule
